/* hdl/range_residual_accumulator_defines.svh */
// assertion macros shared by the range residual accumulator rtl
`ifndef RANGE_RESIDUAL_ACCUMULATOR_DEFINES_SVH
`define RANGE_RESIDUAL_ACCUMULATOR_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define RRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rra_pkg.sv */
// types and constants for the range residual accumulator
`timescale 1ns / 1ps

package rra_pkg;

    localparam int COORD_BITS = 24;
    localparam int RANGE_BITS = COORD_BITS - 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = DIFF_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SUM_W      = 60;
    localparam int CNT_W      = 16;
    localparam int ITER_W     = 5;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(ROOT_W - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

    // register index, taken from paddr[2]
    localparam logic REG_CANDIDATE_X = 1'b0;
    localparam logic REG_CANDIDATE_Y = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] anchor_x;
        logic signed [COORD_BITS-1:0] anchor_y;
        logic [RANGE_BITS-1:0]        measured_range;
        logic                         last_anchor;
    } anchor_t;

    typedef struct packed {
        logic [SUM_W-1:0] residual_sum;
        logic [CNT_W-1:0] anchor_count;
        logic             saturated;
    } result_t;

endpackage

/* hdl/range_residual_accumulator.sv */
// top level of the range residual accumulator
`timescale 1ns / 1ps
`include "range_residual_accumulator_defines.svh"

// usage:
// anchor channel (anchor_valid/anchor_ready/anchor) carries one anchor per request:
// x, y, measured range and a last flag. the block squares dx and dy on one shared
// 25x25 multiplier, adds them, takes a restoring square root one result bit per
// cycle, then squares the range error on the same multiplier and accumulates.
// each request occupies the block from acceptance through its steps (two squares,
// one add, 25 root steps, difference, square, accumulate); anchor_ready is high
// again in the cycle after the accumulate step, so the block takes no new anchor
// until the previous one is through.
// result channel (result_valid/result_ready/result) gets one request after the
// anchor marked last: saturating sum, anchor count and saturation flag.
// the result sits in an output register, so the next anchor set proceeds while
// it waits; only a second last anchor holds in its accumulate step until the
// receiver takes the earlier result.
// user writes candidate_x/candidate_y over the apb port only while idle; unchecked.
// reset clears candidate, sum, count, flag and all handshakes.
module range_residual_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          anchor_valid,
    output logic                          anchor_ready,
    input  rra_pkg::anchor_t              anchor,
    output logic                          result_valid,
    input  logic                          result_ready,
    output rra_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rra_pkg::ADDR_W-1:0]    paddr,
    input  logic [rra_pkg::DATA_W-1:0]    pwdata,
    output logic [rra_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import rra_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQX  = 3'd1;
    localparam logic [2:0] S_SQY  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DIFF = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_ACC  = 3'd7;

    logic [2:0]                   state_reg;
    logic signed [COORD_BITS-1:0] cand_x_reg;
    logic signed [COORD_BITS-1:0] cand_y_reg;
    logic [DIFF_W-1:0]            adx_reg;
    logic [DIFF_W-1:0]            ady_reg;
    logic [RANGE_BITS-1:0]        range_reg;
    logic                         last_reg;
    logic [SQ_W-1:0]              mul_reg;
    logic [SQ_W-1:0]              rad_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [ROOT_W-1:0]            root_reg;
    logic [ITER_W-1:0]            iter_reg;
    logic [DIFF_W-1:0]            mag_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         clip_reg;
    logic                         res_valid_reg;
    result_t                      res_reg;

    logic                         anchor_fire;
    logic                         result_fire;
    logic                         cfg_write;
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;
    logic [DIFF_W-1:0]            mul_op;
    logic [SQ_W-1:0]              mul_prod;
    logic [REM_W+2:0]             trial;
    logic [SUM_W:0]               sum_wide;
    logic [SUM_W-1:0]             sum_next;
    logic                         clip_next;
    logic [CNT_W-1:0]             cnt_next;
    logic                         out_free;
    logic [REM_W-1:0]             root_dbl;

    assign anchor_fire  = anchor_valid && anchor_ready;
    assign result_fire  = res_valid_reg && result_ready;
    assign anchor_ready = (state_reg == S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign out_free     = !res_valid_reg || result_ready;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_CANDIDATE_X: prdata = {{(DATA_W-COORD_BITS){1'b0}}, cand_x_reg};
            REG_CANDIDATE_Y: prdata = {{(DATA_W-COORD_BITS){1'b0}}, cand_y_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_x_reg <= '0;
            cand_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CANDIDATE_X)
                cand_x_reg <= pwdata[COORD_BITS-1:0];
            else
                cand_y_reg <= pwdata[COORD_BITS-1:0];
        end
    end

    // offsets from the candidate
    assign dx = DIFF_W'(anchor.anchor_x) - DIFF_W'(cand_x_reg);
    assign dy = DIFF_W'(anchor.anchor_y) - DIFF_W'(cand_y_reg);

    // shared squaring multiplier
    always_comb
    begin
        case (state_reg)
            S_SQX:   mul_op = adx_reg;
            S_SQY:   mul_op = ady_reg;
            default: mul_op = mag_reg;
        endcase
    end
    assign mul_prod = SQ_W'(mul_op) * SQ_W'(mul_op);

    // one restoring square root step: bring down two bits and try subtracting
    assign trial = {1'b0, rem_reg, rad_reg[SQ_W-1:SQ_W-2]}
                 - {2'b00, root_reg, 2'b01};
    assign root_dbl = {root_reg, 1'b0};

    // saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(mul_reg);
    always_comb
    begin
        if (sum_wide >= {1'b0, SUM_MAX})
        begin
            sum_next  = SUM_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            sum_next  = sum_wide[SUM_W-1:0];
            clip_next = clip_reg;
        end
        cnt_next = (cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            clip_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // result register: loaded on a last anchor, freed when taken
            if (state_reg == S_ACC && last_reg && out_free)
                res_valid_reg <= 1'b1;
            else if (result_fire)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (anchor_fire)
                        state_reg <= S_SQX;
                end
                S_SQX:
                    state_reg <= S_SQY;
                S_SQY:
                    state_reg <= S_ADD;
                S_ADD:
                begin
                    iter_reg  <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == SQRT_LAST)
                        state_reg <= S_DIFF;
                end
                S_DIFF:
                    state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    if (!last_reg)
                    begin
                        sum_reg   <= sum_next;
                        cnt_reg   <= cnt_next;
                        clip_reg  <= clip_next;
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        clip_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (anchor_fire)
        begin
            adx_reg   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
            ady_reg   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            range_reg <= anchor.measured_range;
            last_reg  <= anchor.last_anchor;
        end
        if (state_reg == S_SQX || state_reg == S_SQY || state_reg == S_MUL)
            mul_reg <= mul_prod;
        if (state_reg == S_SQY)
            rad_reg <= mul_reg;
        if (state_reg == S_ADD)
        begin
            rad_reg  <= rad_reg + mul_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == S_SQRT)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (!trial[REM_W+2])
            begin
                rem_reg  <= trial[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[REM_W-3:0], rad_reg[SQ_W-1:SQ_W-2]};
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (state_reg == S_DIFF)
        begin
            if (root_reg >= ROOT_W'(range_reg))
                mag_reg <= root_reg - ROOT_W'(range_reg);
            else
                mag_reg <= ROOT_W'(range_reg) - root_reg;
        end
        if (state_reg == S_ACC && last_reg && out_free)
        begin
            res_reg.residual_sum <= sum_next;
            res_reg.anchor_count <= cnt_next;
            res_reg.saturated    <= clip_next;
        end
    end

    // checks
    `RRA_ASSERT_NEXT(a_accept_starts, anchor_fire, state_reg == S_SQX,
        "accepted anchor did not start the sequence")
    `RRA_ASSERT_NOW(a_root_remainder, state_reg == S_DIFF, rem_reg <= root_dbl,
        "square root remainder exceeds twice the root")
    `RRA_ASSERT_NOW(a_sat_at_ceiling, result_valid && result.saturated,
        result.residual_sum == SUM_MAX, "saturated result below the ceiling")
    `RRA_ASSERT_NOW(a_count_nonzero, result_valid, result.anchor_count != '0,
        "result carries a zero anchor count")

endmodule
